// ----- rtl/core/qte_pkg.sv -----
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants, types and the CORDIC arctangent table for the
// quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_STAGES_DEF = 16;

  localparam int Q_W      = 16;
  localparam int PROD_W   = 32;
  localparam int TERM_W   = 34;
  localparam int CX_W     = 38;
  localparam int ANG_W    = 34;
  localparam int ROOT_W   = 31;
  localparam int SQ_W     = 62;
  localparam int SQRT_ITS = 31;
  localparam int SQRT_LAT = SQRT_ITS + 2;
  localparam int MUL_W    = 52;
  localparam int RES_W    = MUL_W - 32;

  localparam logic signed [TERM_W-1:0] ONE_Q30     = TERM_W'(64'sd1073741824);
  localparam logic signed [ANG_W-1:0]  TURN_QUART  = ANG_W'(64'sd1073741824);
  localparam logic signed [17:0]       DEG_SCALE   = 18'sd46080;
  localparam logic signed [RES_W-1:0]  PITCH_LIM   = RES_W'(32'sd11520);
  localparam logic signed [RES_W-1:0]  ANGLE_LIM   = RES_W'(32'sd23040);

  typedef struct packed {
    logic signed [TERM_W-1:0] sr;
    logic signed [TERM_W-1:0] cr;
    logic signed [TERM_W-1:0] sp;
    logic signed [TERM_W-1:0] sy;
    logic signed [TERM_W-1:0] cy;
  } terms_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/quaternion_to_euler_degrees.sv -----
// Throughput: one quaternion per cycle while the output is not stalled; the
// 31 iteration stages of the square root on the pitch path and the CORDIC
// stage count set the depth.
// The whole pipeline holds while a result waits, so nothing is lost or repeated.
// Reset clears only the valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees
// Unit quaternion in Q1.15 to roll, pitch and yaw in 1/128 degree, with a
// gimbal lock flag, through fully pipelined CORDIC atan2 units.
// ----------------------------------------------------------------------------
module quaternion_to_euler_degrees
  import qte_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic signed [15:0] roll_angle_o,
  output logic               pitch_saturated_o
);

  localparam int SideW = 5 * TERM_W + 1;
  localparam int CordLat = CORDIC_STAGES + 1;

  logic                    en;
  logic                    prod_valid, sqrt_valid, cord_valid;
  terms_t                  terms, terms_d;
  logic                    sat, sat_d1, sat_d2, neg_d2;
  logic [ROOT_W-1:0]       root;
  logic [SideW-1:0]        side_d;
  logic signed [ANG_W-1:0] roll_ang, yaw_ang, pitch_ang;

  assign en      = !valid_o || ready_i;
  assign ready_o = en;

  qte_products u_products (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (valid_i),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .valid_o  (prod_valid),
    .terms_o  (terms),
    .sat_o    (sat)
  );

  qte_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prod_valid),
    .sine_i  (terms.sp),
    .valid_o (sqrt_valid),
    .root_o  (root)
  );

  qte_delay #(.WIDTH(SideW), .DEPTH(SQRT_LAT)) u_side_delay (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i ({terms, sat}),
    .data_o (side_d)
  );

  assign terms_d = side_d[SideW-1:1];
  assign sat_d1  = side_d[0];

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_valid),
    .sin_i   (terms_d.sr),
    .cos_i   (terms_d.cr),
    .valid_o (cord_valid),
    .angle_o (roll_ang)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_valid),
    .sin_i   (terms_d.sy),
    .cos_i   (terms_d.cy),
    .valid_o (),
    .angle_o (yaw_ang)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_valid),
    .sin_i   (terms_d.sp),
    .cos_i   (TERM_W'(root)),
    .valid_o (),
    .angle_o (pitch_ang)
  );

  qte_delay #(.WIDTH(2), .DEPTH(CordLat)) u_flag_delay (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i ({sat_d1, terms_d.sp[TERM_W-1]}),
    .data_o ({sat_d2, neg_d2})
  );

  qte_scale u_scale (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .valid_i           (cord_valid),
    .roll_i            (roll_ang),
    .yaw_i             (yaw_ang),
    .pitch_i           (pitch_ang),
    .sat_i             (sat_d2),
    .neg_i             (neg_d2),
    .valid_o           (valid_o),
    .pitch_angle_o     (pitch_angle_o),
    .yaw_angle_o       (yaw_angle_o),
    .roll_angle_o      (roll_angle_o),
    .pitch_saturated_o (pitch_saturated_o)
  );

endmodule

// ----- rtl/core/qte_delay.sv -----
// ----------------------------------------------------------------------------
// qte_delay
// Enabled shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module qte_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= data_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign data_o = tap_q[DEPTH-1];

endmodule

// ----- rtl/core/qte_products.sv -----
// ----------------------------------------------------------------------------
// qte_products
// Two stages: the nine component products, then the five Q30 terms and the
// gimbal lock flag.
// ----------------------------------------------------------------------------
module qte_products
  import qte_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [Q_W-1:0] quat_w_i,
  input  logic signed [Q_W-1:0] quat_x_i,
  input  logic signed [Q_W-1:0] quat_y_i,
  input  logic signed [Q_W-1:0] quat_z_i,
  output logic                  valid_o,
  output terms_t                terms_o,
  output logic                  sat_o
);

  logic signed [PROD_W-1:0] wx_q, yz_q, wy_q, zx_q, wz_q, xy_q, xx_q, yy_q, zz_q;
  logic                     v1_q, v2_q;
  terms_t                   terms_d, terms_q;
  logic                     sat_d, sat_q;

  always_comb begin
    terms_d.sr = (TERM_W'(wx_q) + TERM_W'(yz_q)) <<< 1;
    terms_d.cr = ONE_Q30 - ((TERM_W'(xx_q) + TERM_W'(yy_q)) <<< 1);
    terms_d.sp = (TERM_W'(wy_q) - TERM_W'(zx_q)) <<< 1;
    terms_d.sy = (TERM_W'(wz_q) + TERM_W'(xy_q)) <<< 1;
    terms_d.cy = ONE_Q30 - ((TERM_W'(yy_q) + TERM_W'(zz_q)) <<< 1);
    sat_d = (terms_d.sp >= ONE_Q30) || (terms_d.sp <= -ONE_Q30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q    <= quat_w_i * quat_x_i;
      yz_q    <= quat_y_i * quat_z_i;
      wy_q    <= quat_w_i * quat_y_i;
      zx_q    <= quat_z_i * quat_x_i;
      wz_q    <= quat_w_i * quat_z_i;
      xy_q    <= quat_x_i * quat_y_i;
      xx_q    <= quat_x_i * quat_x_i;
      yy_q    <= quat_y_i * quat_y_i;
      zz_q    <= quat_z_i * quat_z_i;
      terms_q <= terms_d;
      sat_q   <= sat_d;
    end
  end

  assign valid_o = v2_q;
  assign terms_o = terms_q;
  assign sat_o   = sat_q;

endmodule

// ----- rtl/core/qte_isqrt.sv -----
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined cosine of the pitch: square, subtract from one, then a truncating
// integer square root that resolves one result bit per stage.
// ----------------------------------------------------------------------------
module qte_isqrt
  import qte_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [TERM_W-1:0] sine_i,
  output logic                     valid_o,
  output logic [ROOT_W-1:0]        root_o
);

  logic [ROOT_W-1:0] mag;
  logic [SQ_W-1:0]   sq_q;
  logic              vsq_q;
  logic [SQ_W-1:0]   n_q   [SQRT_ITS+1];
  logic [SQ_W-1:0]   res_q [SQRT_ITS+1];
  logic              v_q   [SQRT_ITS+1];

  // The sine is below one in magnitude whenever the root is used.
  assign mag = sine_i[ROOT_W-1] ? ROOT_W'(-sine_i[ROOT_W-1:0]) : sine_i[ROOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsq_q  <= 1'b0;
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      vsq_q  <= valid_i;
      v_q[0] <= vsq_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q     <= SQ_W'(mag) * SQ_W'(mag);
      n_q[0]   <= (SQ_W'(1) << 60) - sq_q;
      res_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQRT_ITS; k++) begin : g_iter
    localparam logic [SQ_W-1:0] Bit = SQ_W'(1) << (60 - 2 * k);
    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] n_d, res_d;

    always_comb begin
      trial = res_q[k] + Bit;
      if (n_q[k] >= trial) begin
        n_d   = n_q[k] - trial;
        res_d = (res_q[k] >> 1) + Bit;
      end else begin
        n_d   = n_q[k];
        res_d = res_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k+1]   <= n_d;
        res_q[k+1] <= res_d;
      end
    end
  end

  assign valid_o = v_q[SQRT_ITS];
  assign root_o  = res_q[SQRT_ITS][ROOT_W-1:0];

endmodule

// ----- rtl/core/qte_cordic.sv -----
// ----------------------------------------------------------------------------
// qte_cordic
// Vectoring CORDIC for atan2: a quarter-turn pre-rotation stage followed by
// one registered micro-rotation per stage.
// ----------------------------------------------------------------------------
module qte_cordic
  import qte_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [TERM_W-1:0] sin_i,
  input  logic signed [TERM_W-1:0] cos_i,
  output logic                     valid_o,
  output logic signed [ANG_W-1:0]  angle_o
);

  logic signed [CX_W-1:0]  x_q [STAGES+1];
  logic signed [CX_W-1:0]  y_q [STAGES+1];
  logic signed [ANG_W-1:0] z_q [STAGES+1];
  logic                    v_q [STAGES+1];

  logic signed [CX_W-1:0]  x0_d, y0_d, cx, sy;
  logic signed [ANG_W-1:0] z0_d;

  always_comb begin
    cx = CX_W'(cos_i);
    sy = CX_W'(sin_i);
    x0_d = cx;
    y0_d = sy;
    z0_d = '0;
    if (cx < 0) begin
      if (sy >= 0) begin
        x0_d = sy;
        y0_d = -cx;
        z0_d = TURN_QUART;
      end else begin
        x0_d = -sy;
        y0_d = cx;
        z0_d = -TURN_QUART;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= x0_d;
      y_q[0] <= y0_d;
      z_q[0] <= z0_d;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [CX_W-1:0]  dx, dy, x_d, y_d;
    logic signed [ANG_W-1:0] step, z_d;

    always_comb begin
      dx   = y_q[i] >>> i;
      dy   = x_q[i] >>> i;
      step = ANG_W'(atan_entry(5'(i)));
      x_d  = x_q[i];
      y_d  = y_q[i];
      z_d  = z_q[i];
      if (y_q[i] > 0) begin
        x_d = x_q[i] + dx;
        y_d = y_q[i] - dy;
        z_d = z_q[i] + step;
      end else if (y_q[i] < 0) begin
        x_d = x_q[i] - dx;
        y_d = y_q[i] + dy;
        z_d = z_q[i] - step;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1] <= x_d;
        y_q[i+1] <= y_d;
        z_q[i+1] <= z_d;
      end
    end
  end

  assign valid_o = v_q[STAGES];
  assign angle_o = z_q[STAGES];

endmodule

// ----- rtl/core/qte_scale.sv -----
// ----------------------------------------------------------------------------
// qte_scale
// Converts turn fractions to 1/128 degree: multiply, then round, clamp and
// apply the gimbal lock override into the output registers.
// ----------------------------------------------------------------------------
module qte_scale
  import qte_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [ANG_W-1:0] roll_i,
  input  logic signed [ANG_W-1:0] yaw_i,
  input  logic signed [ANG_W-1:0] pitch_i,
  input  logic                    sat_i,
  input  logic                    neg_i,
  output logic                    valid_o,
  output logic signed [14:0]      pitch_angle_o,
  output logic signed [15:0]      yaw_angle_o,
  output logic signed [15:0]      roll_angle_o,
  output logic                    pitch_saturated_o
);

  function automatic logic signed [RES_W-1:0] round_clamp(
    input logic signed [MUL_W-1:0] p,
    input logic signed [RES_W-1:0] lim
  );
    logic signed [MUL_W-1:0] s;
    logic signed [RES_W-1:0] r;
    s = p + (MUL_W'(1) <<< 31);
    r = s[MUL_W-1:32];
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  logic signed [MUL_W-1:0] roll_m_q, yaw_m_q, pitch_m_q;
  logic                    sat_q, neg_q, v1_q, v2_q;
  logic signed [RES_W-1:0] pitch_r, yaw_r, roll_r;
  logic signed [14:0]      pitch_q;
  logic signed [15:0]      yaw_q, roll_q;
  logic                    sat_out_q;

  always_comb begin
    roll_r  = round_clamp(roll_m_q, ANGLE_LIM);
    yaw_r   = round_clamp(yaw_m_q, ANGLE_LIM);
    pitch_r = round_clamp(pitch_m_q, PITCH_LIM);
    if (sat_q) begin
      pitch_r = neg_q ? -PITCH_LIM : PITCH_LIM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      roll_m_q  <= MUL_W'(roll_i) * MUL_W'(DEG_SCALE);
      yaw_m_q   <= MUL_W'(yaw_i) * MUL_W'(DEG_SCALE);
      pitch_m_q <= MUL_W'(pitch_i) * MUL_W'(DEG_SCALE);
      sat_q     <= sat_i;
      neg_q     <= neg_i;
      pitch_q   <= pitch_r[14:0];
      yaw_q     <= yaw_r[15:0];
      roll_q    <= roll_r[15:0];
      sat_out_q <= sat_q;
    end
  end

  assign valid_o           = v2_q;
  assign pitch_angle_o     = pitch_q;
  assign yaw_angle_o       = yaw_q;
  assign roll_angle_o      = roll_q;
  assign pitch_saturated_o = sat_out_q;

endmodule

// ----- verif/quaternion_to_euler_degrees_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees_checker
// Watches both channels of the converter, computes the expected Euler angles
// for every accepted quaternion and compares each accepted result with them.
// ----------------------------------------------------------------------------
module quaternion_to_euler_degrees_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic               ready_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic               valid_o,
  input  logic               ready_i,
  input  logic signed [14:0] pitch_angle_o,
  input  logic signed [15:0] yaw_angle_o,
  input  logic signed [15:0] roll_angle_o,
  input  logic               pitch_saturated_o,
  output int                 error_count,
  output int                 pending_count
);

  localparam int STAGES = 16;
  localparam longint ONE = 64'sd1073741824;

  typedef struct packed {
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] roll;
    logic               sat;
  } euler_t;

  euler_t expected_angles[$];

  function automatic longint arc_table(int i);
    longint t[32] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
      64'h00000001, 64'h00000000};
    return t[i];
  endfunction

  function automatic longint vector_angle(longint sv, longint cv);
    longint x, y, z, t, dx, dy;
    x = cv;
    y = sv;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = ONE;
      end else begin
        x = -y; y = t; z = -ONE;
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arc_table(i);
      end else if (y < 0) begin
        x -= dx; y += dy; z -= arc_table(i);
      end
    end
    return z;
  endfunction

  function automatic longint to_degrees(longint ang, longint lim);
    longint r;
    r = (ang * 46080 + (64'sd1 <<< 31)) >>> 32;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic euler_t predict_angles(longint w, longint x, longint y, longint z);
    euler_t e;
    longint sr, cr, sp, sy, cy, p;
    sr = 2 * (w * x + y * z);
    cr = ONE - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = ONE - 2 * (y * y + z * z);
    e.roll = 16'(to_degrees(vector_angle(sr, cr), 23040));
    e.yaw = 16'(to_degrees(vector_angle(sy, cy), 23040));
    if (sp >= ONE || sp <= -ONE) begin
      p = sp > 0 ? 11520 : -11520;
      e.sat = 1'b1;
    end else begin
      p = to_degrees(vector_angle(sp, floor_sqrt((64'd1 << 60) - longint'(sp * sp))),
                     11520);
      e.sat = 1'b0;
    end
    e.pitch = 15'(p);
    return e;
  endfunction

  euler_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_count <= 0;
      expected_angles.delete();
    end else begin
      if (valid_i && ready_o) begin
        expected_angles.insert(expected_angles.size(),
                               predict_angles(quat_w_i, quat_x_i, quat_y_i, quat_z_i));
      end
      if (valid_o && ready_i) begin
        got = '{pitch_angle_o, yaw_angle_o, roll_angle_o, pitch_saturated_o};
        if (expected_angles.size() == 0) begin
          $display("%0t: result with nothing expected, actual %p", $time, got);
          error_count <= error_count + 1;
        end else begin
          want = expected_angles.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
            error_count <= error_count + 1;
          end
        end
      end
    end
  end

  assign pending_count = expected_angles.size();

endmodule

// ----- verif/quaternion_to_euler_degrees_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees_tb
// Drives directed and random quaternions with random idling on both channels
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
module quaternion_to_euler_degrees_tb;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i = 1'b0;
  logic               ready_o;
  logic signed [15:0] quat_w_i = '0;
  logic signed [15:0] quat_x_i = '0;
  logic signed [15:0] quat_y_i = '0;
  logic signed [15:0] quat_z_i = '0;
  logic               valid_o;
  logic               ready_i = 1'b0;
  logic signed [14:0] pitch_angle_o;
  logic signed [15:0] yaw_angle_o;
  logic signed [15:0] roll_angle_o;
  logic               pitch_saturated_o;
  int                 error_count;
  int                 pending_count;
  int                 stall_cycles = 0;
  bit                 steady = 1'b0;

  always #4 clk_i = ~clk_i;

  quaternion_to_euler_degrees DUT (.*);

  quaternion_to_euler_degrees_checker checker_inst (.*);

  always @(posedge clk_i) begin
    ready_i <= steady || ($urandom_range(99) >= 38);
    if ((valid_i && ready_o) || (valid_o && ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (stall_cycles > 2000) begin
      $display("quaternion_to_euler_degrees_tb: done, errors");
      $finish;
    end
  end

  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while (!steady && $urandom_range(99) < 38) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    quat_w_i <= w;
    quat_x_i <= x;
    quat_y_i <= y;
    quat_z_i <= z;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_part();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(1000)) - 16'd500;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int r;
    real a, b, c, d, n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_quat(16'h7FFF, 0, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_quat(16'h5A82, 0, 16'h5A82, 0);
    send_quat(16'h5A82, 0, 16'hA57E, 0);
    send_quat(16'h4000, 16'h4000, 16'h4000, 16'h4000);
    send_quat(16'h4000, 16'hC000, 16'h4000, 16'hC000);
    send_quat(0, 16'h7FFF, 0, 0);
    send_quat(0, 0, 0, 16'h7FFF);
    send_quat(0, 0, 16'h7FFF, 0);
    send_quat(16'h5A82, 16'h5A82, 0, 0);
    send_quat(16'h7FFF, 0, 16'h8000, 0);
    send_quat(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF);
    send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_quat(16'h2D41, 16'h2D41, 16'h2D41, 16'hD2BF);
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    for (int i = 0; i < 1900; i++) begin
      steady = (i >= 600 && i < 800);
      r = $urandom_range(9);
      if (r < 7) begin
        a = $urandom_range(2000) - 1000.0;
        b = $urandom_range(2000) - 1000.0;
        c = $urandom_range(2000) - 1000.0;
        d = $urandom_range(2000) - 1000.0;
        if (r == 0) begin
          c = 1000.0; a = 1000.0 + $urandom_range(3); b = $urandom_range(3); d = b;
        end
        n = $sqrt(a * a + b * b + c * c + d * d) + 0.001;
        send_quat(16'($rtoi(a / n * 32767.0)), 16'($rtoi(b / n * 32767.0)),
                  16'($rtoi(c / n * 32767.0)), 16'($rtoi(d / n * 32767.0)));
      end else begin
        send_quat(pick_part(), pick_part(), pick_part(), pick_part());
      end
    end
    steady = 1'b0;
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (error_count == 0) begin
      $display("quaternion_to_euler_degrees_tb: done, clean");
    end else begin
      $display("quaternion_to_euler_degrees_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/qte_pkg.sv
rtl/core/qte_delay.sv
rtl/core/qte_products.sv
rtl/core/qte_isqrt.sv
rtl/core/qte_cordic.sv
rtl/core/qte_scale.sv
rtl/core/quaternion_to_euler_degrees.sv
verif/quaternion_to_euler_degrees_checker.sv
verif/quaternion_to_euler_degrees_tb.sv
